// ===== sv/sue_pkg.sv =====
// Shared types and constants for the string unescape / UTF-8 encoder.
package sue_pkg;

	// Most result beats one input byte can cause
	localparam int MaxRes  = 7;
	localparam int ResIdxW = $clog2(MaxRes);

	// Command queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// Raw digits kept for replay of a broken escape
	localparam int BufDepth = 5;
	localparam int BufIdxW  = $clog2(BufDepth);

	typedef logic [7:0] byte_t;

	// One queued command: the result beats of one accepted input beat
	typedef struct packed {
		byte_t [MaxRes-1:0]   bytes;     // result bytes, slot 0 goes out first
		logic  [ResIdxW-1:0]  cnt;       // number of result beats, 1..MaxRes
		logic                 has_data;  // 0 for a bare end marker
		logic                 last;      // command closes the string
	} res_entry_t;

	// Queue head as seen by the back end
	typedef struct packed {
		res_entry_t entry;
		logic       valid;
	} q_head_t;

	// Characters of interest
	localparam byte_t ChBackslash = 8'h5C;
	localparam byte_t ChZero      = 8'h30;
	localparam byte_t ChOne       = 8'h31;
	localparam byte_t ChNine      = 8'h39;
	localparam byte_t ChLowA      = 8'h61;
	localparam byte_t ChLowF      = 8'h66;
	localparam byte_t ChUpA       = 8'h41;
	localparam byte_t ChUpF       = 8'h46;
	localparam byte_t ChLowB      = 8'h62;
	localparam byte_t ChLowE      = 8'h65;
	localparam byte_t ChLowN      = 8'h6E;
	localparam byte_t ChLowR      = 8'h72;
	localparam byte_t ChLowT      = 8'h74;
	localparam byte_t ChLowV      = 8'h76;
	localparam byte_t ChLowX      = 8'h78;
	localparam byte_t ChLowU      = 8'h75;
	localparam byte_t ChUpU       = 8'h55;

	// Control bytes produced by simple escapes
	localparam byte_t CtlNul = 8'h00;
	localparam byte_t CtlBel = 8'h07;
	localparam byte_t CtlBs  = 8'h08;
	localparam byte_t CtlTab = 8'h09;
	localparam byte_t CtlLf  = 8'h0A;
	localparam byte_t CtlVt  = 8'h0B;
	localparam byte_t CtlFf  = 8'h0C;
	localparam byte_t CtlCr  = 8'h0D;
	localparam byte_t CtlEsc = 8'h1B;

endpackage

// ===== sv/sue_front.sv =====
// Front end: parses escapes and turns each input beat that yields results, or ends a string, into one queued command.
module sue_front import sue_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  byte_t      in_char,
	input  logic       in_last,
	input  logic       q_full,
	output logic       q_push,
	output res_entry_t q_entry
);

	typedef enum logic [1:0] {HexNone, HexX, HexU, HexBigU} hex_kind_t;

	hex_kind_t     kind_q;
	logic          bs_q;
	logic [2:0]    ds_q;
	logic [20:0]   cp_q;
	byte_t         buf_q [BufDepth];

	logic          accept;
	logic          is_hex;
	logic [3:0]    hv;
	logic          dig_ok;
	logic          in_hex;
	logic          ok;
	logic          brk;
	logic [2:0]    need;
	logic [2:0]    ds_inc;
	logic          done;
	logic [20:0]   new_cp;
	byte_t         u_bytes [4];
	logic [2:0]    u_cnt;
	logic          norm_emit;
	byte_t         norm_byte;
	logic          bs_next;
	hex_kind_t     start_kind;
	logic          ab_list;
	byte_t         tail_byte;
	logic          tail_pres;
	byte_t [MaxRes-1:0] slots;
	logic [ResIdxW-1:0] cnt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Hex digit value of the incoming byte
	always_comb begin
		is_hex = 1'b0;
		hv     = 4'd0;
		if (in_char >= ChZero && in_char <= ChNine) begin
			is_hex = 1'b1;
			hv     = in_char[3:0];
		end else if ((in_char >= ChLowA && in_char <= ChLowF) ||
		             (in_char >= ChUpA && in_char <= ChUpF)) begin
			is_hex = 1'b1;
			hv     = in_char[3:0] + 4'd9;
		end
	end

	// Digit acceptance; \U is limited to 0x10FFFF by its first two digits
	always_comb begin
		dig_ok = is_hex;
		if (kind_q == HexBigU) begin
			if (ds_q == 3'd0 && in_char != ChZero && in_char != ChOne)
				dig_ok = 1'b0;
			if (ds_q == 3'd1 && buf_q[0] == ChOne && in_char != ChZero)
				dig_ok = 1'b0;
		end
	end

	always_comb begin
		unique case (kind_q)
			HexX:    need = 3'd2;
			HexU:    need = 3'd4;
			default: need = 3'd6;
		endcase
	end

	assign in_hex = (kind_q != HexNone);
	assign ok     = in_hex && dig_ok;
	assign brk    = in_hex && !dig_ok;
	assign ds_inc = ds_q + 3'd1;
	assign done   = ok && (ds_inc >= need);
	assign new_cp = {cp_q[16:0], hv};

	// UTF-8 encoding of the completed code point
	always_comb begin
		u_bytes[0] = 8'h00;
		u_bytes[1] = 8'h00;
		u_bytes[2] = 8'h00;
		u_bytes[3] = 8'h00;
		if (new_cp < 21'h80) begin
			u_cnt      = 3'd1;
			u_bytes[0] = new_cp[7:0];
		end else if (new_cp < 21'h800) begin
			u_cnt      = 3'd2;
			u_bytes[0] = 8'hC0 | {3'b000, new_cp[10:6]};
			u_bytes[1] = 8'h80 | {2'b00, new_cp[5:0]};
		end else if (new_cp < 21'h10000) begin
			u_cnt      = 3'd3;
			u_bytes[0] = 8'hE0 | {4'b0000, new_cp[15:12]};
			u_bytes[1] = 8'h80 | {2'b00, new_cp[11:6]};
			u_bytes[2] = 8'h80 | {2'b00, new_cp[5:0]};
		end else if (new_cp < 21'h110000) begin
			u_cnt      = 3'd4;
			u_bytes[0] = 8'hF0 | {5'b00000, new_cp[20:18]};
			u_bytes[1] = 8'h80 | {2'b00, new_cp[17:12]};
			u_bytes[2] = 8'h80 | {2'b00, new_cp[11:6]};
			u_bytes[3] = 8'h80 | {2'b00, new_cp[5:0]};
		end else begin
			u_cnt = 3'd0;
		end
	end

	// Ordinary byte handling, plain or after a backslash
	always_comb begin
		norm_emit  = 1'b0;
		norm_byte  = in_char;
		bs_next    = bs_q;
		start_kind = HexNone;
		if (!bs_q) begin
			if (in_char == ChBackslash)
				bs_next = 1'b1;
			else
				norm_emit = 1'b1;
		end else begin
			bs_next   = 1'b0;
			norm_emit = 1'b1;
			unique case (in_char)
				ChLowA:  norm_byte = CtlBel;
				ChLowB:  norm_byte = CtlBs;
				ChLowE:  norm_byte = CtlEsc;
				ChLowF:  norm_byte = CtlFf;
				ChLowN:  norm_byte = CtlLf;
				ChLowR:  norm_byte = CtlCr;
				ChLowT:  norm_byte = CtlTab;
				ChLowV:  norm_byte = CtlVt;
				ChZero:  norm_byte = CtlNul;
				ChLowX: begin
					norm_emit  = 1'b0;
					start_kind = HexX;
				end
				ChLowU: begin
					norm_emit  = 1'b0;
					start_kind = HexU;
				end
				ChUpU: begin
					norm_emit  = 1'b0;
					start_kind = HexBigU;
				end
				default: norm_byte = in_char;
			endcase
		end
	end

	// Replay list: NUL, buffered digits, then the tail byte
	assign ab_list   = brk || (ok && !done && in_last);
	assign tail_byte = ok ? in_char : norm_byte;
	assign tail_pres = ok ? 1'b1 : norm_emit;

	// Assemble the result slots of this beat
	always_comb begin
		slots = '0;
		cnt   = '0;
		if (ab_list) begin
			slots[0] = CtlNul;
			for (int k = 1; k < BufDepth + 1; k++) begin
				if (ResIdxW'(k) <= ResIdxW'(ds_q))
					slots[k] = buf_q[k-1];
				else if (ResIdxW'(k) == ResIdxW'(ds_q) + ResIdxW'(1))
					slots[k] = tail_byte;
			end
			if (ds_q == 3'(BufDepth))
				slots[MaxRes-1] = tail_byte;
			cnt = ResIdxW'(ds_q) + ResIdxW'(1) + ResIdxW'(tail_pres);
		end else if (done) begin
			for (int k = 0; k < 4; k++)
				slots[k] = u_bytes[k];
			cnt = ResIdxW'(u_cnt);
		end else if (!in_hex) begin
			if (start_kind != HexNone && in_last) begin
				slots[0] = CtlNul;
				cnt      = ResIdxW'(1);
			end else begin
				slots[0] = norm_byte;
				cnt      = ResIdxW'(norm_emit);
			end
		end
	end

	// Command to the queue; a silent last beat becomes a bare marker
	always_comb begin
		q_entry.bytes    = slots;
		q_entry.cnt      = cnt;
		q_entry.has_data = 1'b1;
		q_entry.last     = in_last;
		if (in_last && cnt == '0) begin
			q_entry.bytes    = '0;
			q_entry.cnt      = ResIdxW'(1);
			q_entry.has_data = 1'b0;
		end
	end

	assign q_push = accept && (q_entry.cnt != '0);

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= HexNone;
			bs_q   <= 1'b0;
			ds_q   <= 3'd0;
			cp_q   <= '0;
		end else if (accept) begin
			if (in_last) begin
				kind_q <= HexNone;
				bs_q   <= 1'b0;
				ds_q   <= 3'd0;
				cp_q   <= '0;
			end else if (ok) begin
				if (done) begin
					kind_q <= HexNone;
					ds_q   <= 3'd0;
					cp_q   <= '0;
				end else begin
					ds_q <= ds_inc;
					cp_q <= new_cp;
				end
			end else begin
				bs_q <= bs_next;
				if (start_kind != HexNone) begin
					kind_q <= start_kind;
					ds_q   <= 3'd0;
					cp_q   <= '0;
				end else if (brk) begin
					kind_q <= HexNone;
					ds_q   <= 3'd0;
					cp_q   <= '0;
				end
			end
		end
	end

	// Raw digit buffer, no reset
	always_ff @(posedge clk) begin
		if (accept && ok && !done && ds_q < 3'(BufDepth))
			buf_q[ds_q[BufIdxW-1:0]] <= in_char;
	end

endmodule

// ===== sv/sue_queue.sv =====
// Short command queue that decouples the parser from the output drain.
module sue_queue import sue_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  res_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output q_head_t    head
);

	res_entry_t        mem_q [QDepth];
	logic [QPtrW-1:0]  wr_q;
	logic [QPtrW-1:0]  rd_q;
	logic [QCntW-1:0]  cnt_q;

	assign full       = (cnt_q == QCntW'(QDepth));
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPtrW'(1);
			if (pop)
				rd_q <= rd_q + QPtrW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCntW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCntW'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("command popped from empty queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue fill count out of range");

endmodule

// ===== sv/sue_back.sv =====
// Back end: drains queued commands one result beat at a time into the output register.
module sue_back import sue_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output byte_t   out_byte,
	output logic    out_has_data,
	output logic    out_run_last,
	output logic    out_str_end
);

	logic [ResIdxW-1:0] idx_q;
	logic               valid_q;
	byte_t              byte_q;
	logic               has_data_q;
	logic               run_last_q;
	logic               str_end_q;
	logic               load;
	logic               fin;

	assign load = head.valid && (!valid_q || out_ready);
	assign fin  = (idx_q == head.entry.cnt - ResIdxW'(1));
	assign pop  = load && fin;

	// Slot index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= fin ? '0 : idx_q + ResIdxW'(1);
			if (load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q     <= head.entry.bytes[idx_q];
			has_data_q <= head.entry.has_data;
			run_last_q <= fin;
			str_end_q  <= fin && head.entry.last;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign out_has_data = has_data_q;
	assign out_run_last = run_last_q;
	assign out_str_end  = str_end_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (idx_q < head.entry.cnt))
		else $error("slot index beyond command length");

	a_idx_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> head.valid)
		else $error("partly drained command vanished from queue");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && str_end_q) |-> run_last_q)
		else $error("string end beat not marked as run end");

endmodule

// ===== sv/string_unescape_utf8_encoder.sv =====
// Top level of the string unescape / UTF-8 encoder.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata char_in[7:0], tlast last_char
//  m_      | out | m_tvalid/m_tready  | tdata byte_out[7:0], tlast run_last,
//          |     |                    | tuser {string_end, byte_valid}
//
// One input byte is taken per cycle while the command queue (4 entries) has room.
// Each input beat yields 0..7 result beats, drained by the back end at one beat per
// cycle while m_tready is high; an accepted byte passes through the queue storage
// and the output register before its first result beat appears.
// Asynchronous active-low reset clears parser state, queue and output valid.
// Output stalls fill the queue; the input stalls only when the queue is full.
module string_unescape_utf8_encoder import sue_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] byte_out
	output logic       m_tlast,
	output logic [1:0] m_tuser    // [0] byte_valid, [1] string_end
);

	logic       q_full;
	logic       q_push;
	logic       q_pop;
	res_entry_t q_entry;
	q_head_t    q_head;
	logic       has_data;
	logic       str_end;

	sue_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	sue_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head)
	);

	sue_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.out_has_data (has_data),
		.out_run_last (m_tlast),
		.out_str_end  (str_end)
	);

	assign m_tuser = {str_end, has_data};

endmodule

// ===== bench/string_unescape_utf8_encoder_tb.sv =====
// Self-checking testbench for the string unescape / UTF-8 encoder stream block.
module string_unescape_utf8_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sue_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 16;

	// Hex escape being collected
	typedef enum logic [1:0] {
		HEX_NONE,
		HEX_TWO,
		HEX_FOUR,
		HEX_SIX
	} hex_mode_e;

	// How the receiver stalls
	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_e;

	// One expected output beat
	typedef struct packed {
		byte_t data;
		logic  valid;
		logic  run_last;
		logic  str_end;
	} out_beat_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	string_unescape_utf8_encoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] char_in
		.s_tlast  (s_tlast),   // last_char
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] byte_out
		.m_tlast  (m_tlast),   // run_last
		.m_tuser  (m_tuser)    // [0] byte_valid, [1] string_end
	);

	// Unescaper state mirrored by the bench
	logic      esc_pending;
	hex_mode_e hex_mode;
	logic [2:0]  hex_count;
	logic [20:0] cp_acc;
	byte_t     digit_hold [BufDepth];

	byte_t     char_bytes[$];    // bytes produced by the byte being predicted
	out_beat_t unescaped_due[$]; // output beats still to arrive
	byte_t     str_buf[$];       // string being built for sending

	int       error_count = 0;
	int       cycle_count = 0;
	int       hold_left = 0;
	int       burst_left = 0;
	bit       tx_gaps_on = 0;
	rx_mode_e rx_mode = RX_FREE;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog
	initial begin
		while (cycle_count < CycleLimit) @(posedge clk);
		$display("[%0t] timeout after %0d cycles", $time, cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------- predictor

	function automatic int nibble_of(byte_t c);
		if (c >= ChZero && c <= ChNine) return int'(c) - int'(ChZero);
		if (c >= ChLowA && c <= ChLowF) return int'(c) - int'(ChLowA) + 10;
		if (c >= ChUpA && c <= ChUpF) return int'(c) - int'(ChUpA) + 10;
		return -1;
	endfunction

	function automatic int digits_for(hex_mode_e m);
		case (m)
			HEX_TWO:  return 2;
			HEX_FOUR: return 4;
			default:  return 6;
		endcase
	endfunction

	// \U limits the first two digits so the code point stays below 0x110000
	function automatic bit digit_allowed(byte_t c);
		if (nibble_of(c) < 0) return 1'b0;
		if (hex_mode == HEX_SIX) begin
			if (hex_count == 0) return (c == ChZero) || (c == ChOne);
			if (hex_count == 1 && digit_hold[0] == ChOne) return c == ChZero;
		end
		return 1'b1;
	endfunction

	task automatic push_byte(input byte_t b);
		if (char_bytes.size() < MaxRes) char_bytes.push_back(b);
	endtask

	task automatic clear_hex();
		hex_mode = HEX_NONE;
		hex_count = '0;
		cp_acc = '0;
	endtask

	task automatic push_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			push_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			push_byte(8'hC0 | cp[10:6]);
			push_byte(8'h80 | cp[5:0]);
		end else if (cp < 21'h10000) begin
			push_byte(8'hE0 | cp[15:12]);
			push_byte(8'h80 | cp[11:6]);
			push_byte(8'h80 | cp[5:0]);
		end else if (cp < 21'h110000) begin
			push_byte(8'hF0 | cp[20:18]);
			push_byte(8'h80 | cp[17:12]);
			push_byte(8'h80 | cp[11:6]);
			push_byte(8'h80 | cp[5:0]);
		end
	endtask

	// Broken or unfinished hex escape: NUL, then the raw digits
	task automatic drop_hex();
		push_byte(CtlNul);
		for (int k = 0; k < hex_count && k < BufDepth; k++) push_byte(digit_hold[k]);
		clear_hex();
	endtask

	task automatic parse_char(input byte_t c);
		logic [3:0] nib;
		if (hex_mode != HEX_NONE) begin
			if (digit_allowed(c) && hex_count < 6) begin
				nib = 4'(nibble_of(c));
				if (hex_count < BufDepth) digit_hold[hex_count] = c;
				cp_acc = {cp_acc[16:0], nib};
				hex_count++;
				if (hex_count >= digits_for(hex_mode)) begin
					push_utf8(cp_acc);
					clear_hex();
				end
				return;
			end
			drop_hex();
		end
		if (!esc_pending) begin
			if (c == ChBackslash) esc_pending = 1'b1;
			else push_byte(c);
			return;
		end
		esc_pending = 1'b0;
		case (c)
			ChLowA:  push_byte(CtlBel);
			ChLowB:  push_byte(CtlBs);
			ChLowE:  push_byte(CtlEsc);
			ChLowF:  push_byte(CtlFf);
			ChLowN:  push_byte(CtlLf);
			ChLowR:  push_byte(CtlCr);
			ChLowT:  push_byte(CtlTab);
			ChLowV:  push_byte(CtlVt);
			ChZero:  push_byte(CtlNul);
			ChLowX:  hex_mode = HEX_TWO;
			ChLowU:  hex_mode = HEX_FOUR;
			ChUpU:   hex_mode = HEX_SIX;
			default: push_byte(c);
		endcase
	endtask

	// Expected output beats for one accepted input beat
	task automatic unescape_char(input byte_t c, input bit last);
		out_beat_t b;
		char_bytes.delete();
		parse_char(c);
		if (last) begin
			if (hex_mode != HEX_NONE) drop_hex();
			esc_pending = 1'b0;
			clear_hex();
		end
		if (char_bytes.size() == 0) begin
			// bare end marker
			if (last) begin
				b = '{data: 8'h00, valid: 1'b0, run_last: 1'b1, str_end: 1'b1};
				unescaped_due.push_back(b);
			end
		end else begin
			for (int k = 0; k < char_bytes.size(); k++) begin
				b.data = char_bytes[k];
				b.valid = 1'b1;
				b.run_last = (k == char_bytes.size() - 1);
				b.str_end = b.run_last && last;
				unescaped_due.push_back(b);
			end
		end
	endtask

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : check_out
		out_beat_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (unescaped_due.size() == 0) begin
				report_mismatch($sformatf("unexpected beat data=%02h last=%b user=%b",
					m_tdata, m_tlast, m_tuser));
			end else begin
				want = unescaped_due.pop_front();
				if (m_tdata !== want.data)
					report_mismatch($sformatf("byte_out %02h, want %02h", m_tdata, want.data));
				if (m_tuser[0] !== want.valid)
					report_mismatch($sformatf("byte_valid %b, want %b", m_tuser[0], want.valid));
				if (m_tlast !== want.run_last)
					report_mismatch($sformatf("run_last %b, want %b", m_tlast, want.run_last));
				if (m_tuser[1] !== want.str_end)
					report_mismatch($sformatf("string_end %b, want %b", m_tuser[1], want.str_end));
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	initial begin : rx_drive
		int phase;
		phase = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			phase = (phase + 1) % 7;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_FREE:   m_tready <= 1'b1;
					RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
					default:   m_tready <= (phase >= 3);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// Offer one byte, wait for the handshake, then predict its output
	task automatic send_char(input byte_t c, input bit last);
		int gap;
		if (tx_gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		unescape_char(c, last);
	endtask

	task automatic send_string();
		for (int i = 0; i < str_buf.size(); i++) send_char(str_buf[i], i == str_buf.size() - 1);
	endtask

	// Drop valid and wait until every predicted beat has come out
	task automatic pause_sender();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (unescaped_due.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- string generator

	function automatic byte_t hex_digit_for(input bit six, input int pos, input byte_t first);
		int r;
		if (six && pos == 0) return ($urandom_range(0, 1) != 0) ? ChOne : ChZero;
		if (six && pos == 1 && first == ChOne) return ChZero;
		r = $urandom_range(0, 21);
		if (r < 10) return byte_t'(ChZero + r);
		if (r < 16) return byte_t'(ChLowA + r - 10);
		return byte_t'(ChUpA + r - 16);
	endfunction

	function automatic byte_t simple_esc_char(input int i);
		case (i)
			0:       return ChLowA;
			1:       return ChLowB;
			2:       return ChLowE;
			3:       return ChLowF;
			4:       return ChLowN;
			5:       return ChLowR;
			6:       return ChLowT;
			7:       return ChLowV;
			8:       return ChZero;
			9:       return ChBackslash;
			10:      return 8'h27;
			default: return 8'h22;
		endcase
	endfunction

	// Append one token; at the open end of a string a hex escape may stay unfinished
	task automatic add_token(input bit open_end);
		int pick, kind, ndig, keep, n;
		byte_t d, first;
		if (open_end) pick = ($urandom_range(0, 2) == 0) ? 200 : 100;
		else pick = $urandom_range(0, 99);
		if (pick < 25) begin
			// plain byte
			d = byte_t'($urandom_range(0, 255));
			if (d == ChBackslash) d = ChUpA;
			str_buf.push_back(d);
		end else if (pick < 40) begin
			str_buf.push_back(ChBackslash);
			str_buf.push_back(simple_esc_char($urandom_range(0, 11)));
		end else if (pick < 48) begin
			// escape of any byte
			str_buf.push_back(ChBackslash);
			str_buf.push_back(byte_t'($urandom_range(0, 255)));
		end else if (pick < 92 || pick == 100) begin
			// hex escape: whole below 80, broken up to 91, unfinished at 100
			kind = $urandom_range(0, 2);
			ndig = 2 * (kind + 1);
			str_buf.push_back(ChBackslash);
			str_buf.push_back(kind == 0 ? ChLowX : (kind == 1 ? ChLowU : ChUpU));
			keep = (pick < 80) ? ndig : $urandom_range(0, ndig - 1);
			first = ChZero;
			for (int i = 0; i < keep; i++) begin
				d = hex_digit_for(kind == 2, i, first);
				if (i == 0) first = d;
				str_buf.push_back(d);
			end
			if (pick >= 80 && pick < 92) begin
				case ($urandom_range(0, 3))
					0:       str_buf.push_back(byte_t'($urandom_range(0, 255)));
					1:       str_buf.push_back(ChBackslash);
					2:       str_buf.push_back(8'h67);
					default: str_buf.push_back(byte_t'(ChZero + $urandom_range(2, 9)));
				endcase
			end
		end else if (pick < 100) begin
			// noise
			n = $urandom_range(1, 3);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) str_buf.push_back(ChBackslash);
				else str_buf.push_back(byte_t'($urandom_range(0, 255)));
			end
		end else begin
			// trailing backslash
			str_buf.push_back(ChBackslash);
		end
	endtask

	task automatic run_random_strings(input int n_items);
		int sent, ntok;
		sent = 0;
		while (sent < n_items) begin
			str_buf.delete();
			ntok = $urandom_range(1, 8);
			for (int t = 0; t < ntok; t++)
				add_token(t == ntok - 1 && $urandom_range(0, 4) == 0);
			send_string();
			sent += str_buf.size();
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		tx_gaps_on = 0;
		rx_mode = RX_FREE;
		// byte extremes, simple escape, NUL escape, unknown escape
		str_buf = '{8'h00, 8'hFF, ChBackslash, ChLowE, ChBackslash, ChZero, ChBackslash, 8'h71};
		send_string();
		// largest code point, four UTF-8 bytes
		str_buf = '{ChBackslash, ChUpU, ChOne, ChZero, ChUpF, ChUpF, ChUpF, ChUpF};
		send_string();
		// two-byte encoding, then a hex escape broken by a non-digit
		str_buf = '{ChBackslash, ChLowX, ChUpF, ChLowF, ChBackslash, ChLowU, ChOne, 8'h67};
		send_string();
		// lone trailing backslash gives a bare end marker
		str_buf = '{ChBackslash};
		send_string();
		// string ends inside a hex escape
		str_buf = '{ChBackslash, ChLowX, 8'h34};
		send_string();
		pause_sender();
	endtask

	task automatic test_random_bursty();
		tx_gaps_on = 1;
		rx_mode = RX_RANDOM;
		run_random_strings(90);
		pause_sender();
	endtask

	// Receiver holds off while the sender keeps offering, so the queue fills
	task automatic test_output_holdoff();
		tx_gaps_on = 0;
		rx_mode = RX_FREE;
		hold_left = 150;
		run_random_strings(30);
		pause_sender();
	endtask

	task automatic test_random_patterned();
		tx_gaps_on = 1;
		rx_mode = RX_PATTERN;
		run_random_strings(60);
		pause_sender();
	endtask

	task automatic test_random_full_rate();
		tx_gaps_on = 0;
		rx_mode = RX_FREE;
		run_random_strings(50);
		pause_sender();
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		esc_pending = 1'b0;
		clear_hex();
		for (int k = 0; k < BufDepth; k++) digit_hold[k] = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_bursty();
		test_output_holdoff();
		test_random_patterned();
		test_random_full_rate();

		// let any stray beats show up
		repeat (DrainCycles) @(posedge clk);
		if (unescaped_due.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", unescaped_due.size()));

		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
